// ===== src/arpc_pkg.sv =====
package arpc_pkg;

    localparam int unsigned IP_W    = 32;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned AGE_W   = 9;
    localparam int unsigned CNT_W   = 5;
    // slot numbers travel at the width of the largest table (256 slots)
    localparam int unsigned SLOT_W  = 8;

    localparam logic [AGE_W-1:0] AGE_MAX   = 9'd511;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [7:0]       AGE_LIMIT_RESET = 8'd20;

    localparam logic REG_AGE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        KIND_LEARN  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    // word moving down the cell chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic              hit;
        logic [MAC_W-1:0]  found_mac;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic [CNT_W-1:0]  expired;
    } t_probe;

    // write of a new entry, broadcast to all cells at the end of a learn
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } t_commit;

endpackage

// ===== src/arpc_cell.sv =====
module arpc_cell #(
    parameter int unsigned SLOT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_age_limit,
    input  arpc_pkg::t_probe  i_probe,
    input  arpc_pkg::t_commit i_commit,
    output arpc_pkg::t_probe  o_probe
);
    import arpc_pkg::*;

    logic             r_valid;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;
    logic [AGE_W-1:0] r_age;
    t_probe           r_probe;

    logic             n_valid;
    logic [IP_W-1:0]  n_ip;
    logic [MAC_W-1:0] n_mac;
    logic [AGE_W-1:0] n_age;
    t_probe           n_probe;

    logic             w_match;
    logic [AGE_W-1:0] w_age_inc;

    assign w_match   = r_valid && (r_ip == i_probe.ip);
    assign w_age_inc = (r_age == AGE_MAX) ? r_age : r_age + 9'd1;

    always_comb begin
        n_probe = i_probe;
        n_valid = r_valid;
        n_ip    = r_ip;
        n_mac   = r_mac;
        n_age   = r_age;
        if (i_probe.valid) begin
            case (i_probe.kind)
                KIND_LEARN: begin
                    if (w_match) begin
                        n_probe.hit = 1'b1;
                    end
                    // remember the lowest free slot
                    if (!r_valid && !i_probe.free_found) begin
                        n_probe.free_found = 1'b1;
                        n_probe.free_slot  = SLOT_W'(SLOT);
                    end
                end
                KIND_LOOKUP: begin
                    if (w_match && !i_probe.hit) begin
                        n_probe.hit       = 1'b1;
                        n_probe.found_mac = r_mac;
                    end
                end
                KIND_TICK: begin
                    if (r_valid) begin
                        n_age = w_age_inc;
                        if (w_age_inc > {1'b0, i_age_limit}) begin
                            n_valid = 1'b0;
                            if (i_probe.expired != COUNT_MAX) begin
                                n_probe.expired = i_probe.expired + 5'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_commit.we && (i_commit.slot == SLOT_W'(SLOT))) begin
            n_valid = 1'b1;
            n_ip    = i_commit.ip;
            n_mac   = i_commit.mac;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_probe <= '0;
        end else begin
            r_valid <= n_valid;
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip  <= n_ip;
        r_mac <= n_mac;
        r_age <= n_age;
    end

    assign o_probe = r_probe;

endmodule

// ===== src/arp_cache_with_aging_top.sv =====
// ARP cache with aging: maps IPv4 addresses to MAC addresses in a table of
// ENTRIES slots, one slot per cell of a chain.
// Input channel (i_valid/o_ready) takes one word per item: learn, lookup or
// one-second tick. Output channel (o_valid/i_ready) returns one result word
// per item: hit, found MAC, inserted, dropped_full, expired_count.
// Each item walks the cell chain one cell per cycle; the result then passes
// through a done register to the output register, and a new item is accepted
// only once the previous result has moved to the output register, so the
// block holds one item in the chain at a time.
// A learn writes its new entry in the cycle its word leaves the last cell.
// If the receiver stalls, the finished result holds in a done register and
// the block stops accepting until the output register frees up; one item may
// be accepted while an earlier result waits at the output.
// Synchronous active-low reset clears all valid bits and sets age_limit to 20.
// The APB port holds age_limit at address 0; pready is always high.
module arp_cache_with_aging_top #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_ip_address,
    input  logic [47:0] i_mac_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [47:0] o_found_mac,
    output logic        o_inserted,
    output logic        o_dropped_full,
    output logic [4:0]  o_expired_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import arpc_pkg::*;

    logic [7:0] r_age_limit;

    logic r_busy;
    logic r_done_valid;
    logic r_out_valid;

    logic             r_done_hit;
    logic [MAC_W-1:0] r_done_mac;
    logic             r_done_ins;
    logic             r_done_drop;
    logic [CNT_W-1:0] r_done_exp;

    logic             r_out_hit;
    logic [MAC_W-1:0] r_out_mac;
    logic             r_out_ins;
    logic             r_out_drop;
    logic [CNT_W-1:0] r_out_exp;

    logic             w_res_hit;
    logic [MAC_W-1:0] w_res_mac;
    logic             w_res_ins;
    logic             w_res_drop;
    logic [CNT_W-1:0] w_res_exp;

    t_probe  w_probe [ENTRIES+1];
    t_probe  w_last;
    t_commit w_commit;
    logic    w_accept;
    logic    w_move;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_AGE_LIMIT) ? {24'd0, r_age_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= AGE_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_AGE_LIMIT)) begin
            r_age_limit <= pwdata[7:0];
        end
    end

    assign o_ready  = !r_busy;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_probe[0]            = '0;
        w_probe[0].valid      = w_accept;
        w_probe[0].kind       = t_kind'(i_kind);
        w_probe[0].ip         = i_ip_address;
        w_probe[0].mac        = i_mac_address;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .SLOT(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_age_limit (r_age_limit),
            .i_probe     (w_probe[g]),
            .i_commit    (w_commit),
            .o_probe     (w_probe[g+1])
        );
    end

    assign w_last = w_probe[ENTRIES];

    always_comb begin
        w_commit.we   = w_last.valid && (w_last.kind == KIND_LEARN) &&
                        !w_last.hit && w_last.free_found;
        w_commit.slot = w_last.free_slot;
        w_commit.ip   = w_last.ip;
        w_commit.mac  = w_last.mac;
    end

    always_comb begin
        w_res_hit  = 1'b0;
        w_res_mac  = '0;
        w_res_ins  = 1'b0;
        w_res_drop = 1'b0;
        w_res_exp  = '0;
        case (w_last.kind)
            KIND_LEARN: begin
                w_res_hit  = w_last.hit;
                w_res_ins  = !w_last.hit && w_last.free_found;
                w_res_drop = !w_last.hit && !w_last.free_found;
            end
            KIND_LOOKUP: begin
                w_res_hit = w_last.hit;
                w_res_mac = w_last.found_mac;
            end
            KIND_TICK: begin
                w_res_exp = w_last.expired;
            end
            default: begin
            end
        endcase
    end

    assign w_move = r_done_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_done_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_last.valid) begin
                r_done_valid <= 1'b1;
            end else if (w_move) begin
                r_done_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_done_hit  <= w_res_hit;
            r_done_mac  <= w_res_mac;
            r_done_ins  <= w_res_ins;
            r_done_drop <= w_res_drop;
            r_done_exp  <= w_res_exp;
        end
        if (w_move) begin
            r_out_hit  <= r_done_hit;
            r_out_mac  <= r_done_mac;
            r_out_ins  <= r_done_ins;
            r_out_drop <= r_done_drop;
            r_out_exp  <= r_done_exp;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_found_mac     = r_out_mac;
    assign o_inserted      = r_out_ins;
    assign o_dropped_full  = r_out_drop;
    assign o_expired_count = r_out_exp;

endmodule
